### rtl/mmfs_pkg.sv
`default_nettype none

package mmfs_pkg;

    localparam int unsigned IDX_W   = 13;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned CNT_W   = 14;
    localparam int unsigned SCL_W   = 17;
    localparam int unsigned QUO_W   = 16;
    localparam int unsigned IDX_X_W = 17;

    localparam logic             KIND_OBSERVE = 1'b0;
    localparam logic             KIND_SCALE   = 1'b1;
    localparam logic [SCL_W-1:0] ONE_Q16      = 17'h10000;
    localparam logic [SCL_W-1:0] ZERO_Q16     = 17'h00000;
    localparam logic [CNT_W-1:0] COUNT_RESET  = 14'd8192;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             min_we;
        logic             max_we;
        logic [VAL_W-1:0] data;
    } t_store_wr;

endpackage

`default_nettype wire

### rtl/mmfs_if.sv
`default_nettype none

interface mmfs_in_if;
    import mmfs_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic [IDX_W-1:0]        feature_index;
    logic                    first_row;
    logic signed [VAL_W-1:0] sample_value;

    modport source (output valid, kind, feature_index, first_row, sample_value,
                    input ready);
    modport sink   (input valid, kind, feature_index, first_row, sample_value,
                    output ready);
endinterface

interface mmfs_out_if;
    import mmfs_pkg::*;
    logic             valid;
    logic             ready;
    logic [SCL_W-1:0] scaled_value;
    logic [IDX_W-1:0] result_index;
    logic             index_error;

    modport source (output valid, scaled_value, result_index, index_error,
                    input ready);
    modport sink   (input valid, scaled_value, result_index, index_error,
                    output ready);
endinterface

`default_nettype wire

### rtl/mmfs_store.sv
`default_nettype none

module mmfs_store
    import mmfs_pkg::*;
#(
    parameter int unsigned DEPTH = 8192,
    parameter int unsigned AW    = 13
) (
    input  wire logic             i_clk,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire t_store_wr        i_wr,
    output logic      [VAL_W-1:0] o_rd_min,
    output logic      [VAL_W-1:0] o_rd_max
);

    logic [VAL_W-1:0] mem_min [DEPTH];
    logic [VAL_W-1:0] mem_max [DEPTH];
    logic [VAL_W-1:0] r_rd_min;
    logic [VAL_W-1:0] r_rd_max;

    always_ff @(posedge i_clk) begin
        if (i_wr.min_we) begin
            mem_min[i_wr_addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_min <= mem_min[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.max_we) begin
            mem_max[i_wr_addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_max <= mem_max[i_rd_addr];
        end
    end

    assign o_rd_min = r_rd_min;
    assign o_rd_max = r_rd_max;

endmodule

`default_nettype wire

### rtl/mmfs_div.sv
`default_nettype none

module mmfs_div
    import mmfs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [VAL_W-1:0] i_dividend,
    input  wire logic [VAL_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [QUO_W-1:0] o_quotient
);

    localparam logic [3:0] LAST_STEP = 4'(QUO_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [3:0]       r_cnt;
    logic [VAL_W-1:0] r_rem;
    logic [VAL_W-1:0] r_dvs;
    logic [QUO_W-1:0] r_quo;

    logic [VAL_W:0]   shifted;
    logic             fits;
    logic [VAL_W:0]   trial;

    // one quotient bit per cycle, remainder stays below the divisor
    always_comb begin
        shifted = {r_rem, 1'b0};
        fits    = shifted >= {1'b0, r_dvs};
        trial   = shifted - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? trial[VAL_W-1:0] : shifted[VAL_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

### rtl/min_max_feature_scaler_core.sv
// channel   dir  handshake      word
// i_in      in   valid/ready    kind, feature_index, first_row, sample_value
// o_out     out  valid/ready    scaled_value, result_index, index_error
// cfg       in   i_cfg_we       i_cfg_wdata = feature_count
//
// one word in flight; observe is accepted, then reads data and writes back in the evaluate state
// scale goes through the 16-step bit-serial divider, or straight to the done state when no division is needed
// out-of-range words skip the memory and go straight from accept to the done state
// a finished word with a result waits in the done state while the output register is still full
// synchronous active-low reset; no word is accepted during reset; memories are not cleared

`default_nettype none

module min_max_feature_scaler_core
    import mmfs_pkg::*;
#(
    parameter int unsigned FEATURE_DEPTH = 8192
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CNT_W-1:0] i_cfg_wdata,
    mmfs_in_if.sink               i_in,
    mmfs_out_if.source            o_out
);

    localparam int unsigned AW = (FEATURE_DEPTH > 1) ? $clog2(FEATURE_DEPTH) : 1;
    localparam logic [IDX_X_W-1:0] DEPTH_X = IDX_X_W'(FEATURE_DEPTH);

    t_state                  r_state;
    t_state                  n_state;
    logic [CNT_W-1:0]        r_feature_count;

    logic                    r_kind;
    logic                    r_first;
    logic signed [VAL_W-1:0] r_x;
    logic [IDX_W-1:0]        r_idx;
    logic [AW-1:0]           r_addr;
    logic [SCL_W-1:0]        r_res_scaled;
    logic                    r_res_err;

    logic                    r_out_valid;
    logic [SCL_W-1:0]        r_out_scaled;
    logic [IDX_W-1:0]        r_out_idx;
    logic                    r_out_err;

    logic [IDX_X_W-1:0]      idx_x;
    logic                    bad;
    logic                    accept;
    logic                    out_free;
    logic                    out_load;
    logic                    rd_en;
    t_store_wr               st_wr;
    logic [VAL_W-1:0]        rd_min;
    logic [VAL_W-1:0]        rd_max;
    logic signed [VAL_W+1:0] span;
    logic signed [VAL_W+1:0] diff;
    logic                    span_zero;
    logic                    diff_zero;
    logic                    diff_full;
    logic                    div_start;
    logic                    div_done;
    logic [QUO_W-1:0]        div_quo;

    assign idx_x    = {{(IDX_X_W - IDX_W){1'b0}}, i_in.feature_index};
    assign bad      = (idx_x >= {{(IDX_X_W - CNT_W){1'b0}}, r_feature_count})
                   || (idx_x >= DEPTH_X);
    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        span      = $signed({{2{rd_max[VAL_W-1]}}, rd_max})
                  - $signed({{2{rd_min[VAL_W-1]}}, rd_min});
        diff      = $signed({{2{r_x[VAL_W-1]}}, r_x})
                  - $signed({{2{rd_min[VAL_W-1]}}, rd_min});
        span_zero = span <= 0;
        diff_zero = diff <= 0;
        diff_full = diff >= span;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        i_in.ready  = 1'b0;
        accept      = 1'b0;
        rd_en       = 1'b0;
        st_wr       = '{min_we: 1'b0, max_we: 1'b0, data: r_x};
        div_start   = 1'b0;
        out_load    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_in.ready = i_rst_n;
                accept     = i_in.valid && i_rst_n;
                rd_en      = accept && !bad;
                if (accept) begin
                    n_state = bad ? ST_DONE : ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (r_kind == KIND_OBSERVE) begin
                    st_wr.min_we = r_first || (r_x < $signed(rd_min));
                    st_wr.max_we = r_first || (r_x > $signed(rd_max));
                    n_state      = ST_IDLE;
                end else if (!span_zero && !diff_zero && !diff_full) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feature_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            r_feature_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind    <= i_in.kind;
            r_first   <= i_in.first_row;
            r_x       <= i_in.sample_value;
            r_idx     <= i_in.feature_index;
            r_addr    <= idx_x[AW-1:0];
            r_res_err <= bad;
            if (bad) begin
                r_res_scaled <= ZERO_Q16;
            end
        end else if (r_state == ST_EVAL) begin
            r_res_scaled <= (!span_zero && !diff_zero && diff_full) ? ONE_Q16 : ZERO_Q16;
        end else if (div_done) begin
            r_res_scaled <= {1'b0, div_quo};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_scaled <= r_res_scaled;
            r_out_idx    <= r_idx;
            r_out_err    <= r_res_err;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.scaled_value = r_out_scaled;
    assign o_out.result_index = r_out_idx;
    assign o_out.index_error  = r_out_err;

    mmfs_store #(
        .DEPTH (FEATURE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (idx_x[AW-1:0]),
        .i_wr_addr (r_addr),
        .i_wr      (st_wr),
        .o_rd_min  (rd_min),
        .o_rd_max  (rd_max)
    );

    mmfs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (diff[VAL_W-1:0]),
        .i_divisor  (span[VAL_W-1:0]),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

`ifndef NO_ASSERTIONS
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == ST_DIV)
        else $error("divider finished outside the divide state");

    a_wr_in_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (st_wr.min_we || st_wr.max_we) |-> (r_state == ST_EVAL && r_kind == KIND_OBSERVE))
        else $error("store written outside an observe update");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.index_error) |-> o_out.scaled_value == ZERO_Q16)
        else $error("index error word with nonzero value");

    a_scaled_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.scaled_value <= ONE_Q16)
        else $error("scaled value above one");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != ST_IDLE)
        else $error("accepted word dropped");
`endif

endmodule

`default_nettype wire

### dv/tb.sv
module tb;
    import mmfs_pkg::*;

    localparam int DEPTH         = 8192;
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 120;
    localparam int RANDOM_WORDS  = 750;
    localparam int PRINT_CAP     = 50;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_op;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] idx;
        logic             first;
        logic [VAL_W-1:0] val;
    } t_in_word;

    typedef struct packed {
        logic [SCL_W-1:0] scaled;
        logic [IDX_W-1:0] idx;
        logic             err;
    } t_scaled_word;

    typedef struct packed {
        t_row_op          op;
        logic             kind;
        logic [IDX_W-1:0] idx;
        logic             first;
        logic [VAL_W-1:0] val;
        logic             known;
        logic [SCL_W-1:0] want_scaled;
        logic             want_err;
    } t_stim_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_wdata;

    mmfs_in_if  in_ch ();
    mmfs_out_if out_ch ();

    min_max_feature_scaler_core #(
        .FEATURE_DEPTH(DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // shadow of the feature bounds and the count register
    int               min_seen [DEPTH];
    int               max_seen [DEPTH];
    bit               written  [DEPTH];
    logic [CNT_W-1:0] feature_limit = COUNT_RESET;

    t_scaled_word due_results [$];
    int           mismatches   = 0;
    int           words_sent   = 0;
    int           quiet_cycles = 0;
    bit           hold_req     = 1'b0;
    bit           snd_idle     = 1'b1;
    bit           rcv_idle     = 1'b1;

    t_stim_row directed_rows [28] = '{
        '{ROW_WORD, KIND_OBSERVE, 13'd0,    1'b1, 32'h8000_0000, 1'b0, ZERO_Q16, 1'b0},
        '{ROW_WORD, KIND_OBSERVE, 13'd0,    1'b0, 32'h7fff_ffff, 1'b0, ZERO_Q16, 1'b0},
        '{ROW_WORD, KIND_OBSERVE, 13'd0,    1'b0, 32'h0000_0000, 1'b0, ZERO_Q16, 1'b0},
        '{ROW_WORD, KIND_SCALE,   13'd0,    1'b0, 32'h8000_0000, 1'b1, ZERO_Q16, 1'b0},
        '{ROW_WORD, KIND_SCALE,   13'd0,    1'b0, 32'h7fff_ffff, 1'b1, ONE_Q16,  1'b0},
        '{ROW_WORD, KIND_SCALE,   13'd0,    1'b0, 32'h0000_0000, 1'b0, ZERO_Q16, 1'b0},
        '{ROW_WORD, KIND_OBSERVE, 13'd8191, 1'b1, 32'h0005_0000, 1'b0, ZERO_Q16, 1'b0},
        '{ROW_WORD, KIND_SCALE,   13'd8191, 1'b0, 32'h0005_0000, 1'b1, ZERO_Q16, 1'b0},
        '{ROW_WORD, KIND_OBSERVE, 13'd1,    1'b1, 32'h0064_0000, 1'b0, ZERO_Q16, 1'b0},
        '{ROW_WORD, KIND_OBSERVE, 13'd1,    1'b0, 32'hff9c_0000, 1'b0, ZERO_Q16, 1'b0},
        '{ROW_WORD, KIND_OBSERVE, 13'd1,    1'b0, 32'h0032_0000, 1'b0, ZERO_Q16, 1'b0},
        '{ROW_WORD, KIND_SCALE,   13'd1,    1'b0, 32'h00c8_0000, 1'b1, ONE_Q16,  1'b0},
        '{ROW_WORD, KIND_SCALE,   13'd1,    1'b0, 32'hfed4_0000, 1'b1, ZERO_Q16, 1'b0},
        '{ROW_WORD, KIND_SCALE,   13'd1,    1'b0, 32'hff9c_0000, 1'b1, ZERO_Q16, 1'b0},
        '{ROW_WORD, KIND_SCALE,   13'd1,    1'b0, 32'h0064_0000, 1'b1, ONE_Q16,  1'b0},
        '{ROW_WORD, KIND_SCALE,   13'd1,    1'b1, 32'h0000_0001, 1'b0, ZERO_Q16, 1'b0},
        '{ROW_CFG,  KIND_OBSERVE, 13'd0,    1'b0, 32'd1,         1'b0, ZERO_Q16, 1'b0},
        '{ROW_WORD, KIND_OBSERVE, 13'd1,    1'b1, 32'h1234_5678, 1'b1, ZERO_Q16, 1'b1},
        '{ROW_WORD, KIND_SCALE,   13'd8191, 1'b0, 32'h0000_0000, 1'b1, ZERO_Q16, 1'b1},
        '{ROW_WORD, KIND_SCALE,   13'd0,    1'b0, 32'h7fff_ffff, 1'b1, ONE_Q16,  1'b0},
        '{ROW_CFG,  KIND_OBSERVE, 13'd0,    1'b0, 32'd0,         1'b0, ZERO_Q16, 1'b0},
        '{ROW_WORD, KIND_OBSERVE, 13'd0,    1'b1, 32'h0000_0000, 1'b1, ZERO_Q16, 1'b1},
        '{ROW_WORD, KIND_SCALE,   13'd0,    1'b0, 32'h0000_0000, 1'b1, ZERO_Q16, 1'b1},
        '{ROW_CFG,  KIND_OBSERVE, 13'd0,    1'b0, 32'd16383,     1'b0, ZERO_Q16, 1'b0},
        '{ROW_WORD, KIND_SCALE,   13'd8191, 1'b0, 32'h0005_0000, 1'b1, ZERO_Q16, 1'b0},
        '{ROW_WORD, KIND_OBSERVE, 13'd8191, 1'b0, 32'hffff_ffff, 1'b0, ZERO_Q16, 1'b0},
        '{ROW_WORD, KIND_SCALE,   13'd8191, 1'b0, 32'h0002_0000, 1'b0, ZERO_Q16, 1'b0},
        '{ROW_CFG,  KIND_OBSERVE, 13'd0,    1'b0, 32'd8192,      1'b0, ZERO_Q16, 1'b0}
    };

    function automatic bit index_ok(logic [IDX_W-1:0] idx);
        return int'(idx) < int'(feature_limit) && int'(idx) < DEPTH;
    endfunction

    function automatic void normalize_word(input t_in_word w, output bit has,
                                           output t_scaled_word r);
        int     x;
        longint span;
        longint diff;
        x = w.val;
        has = 1'b1;
        r = '{ZERO_Q16, w.idx, 1'b0};
        if (!index_ok(w.idx)) begin
            r.err = 1'b1;
            return;
        end
        if (w.kind == KIND_OBSERVE) begin
            has = 1'b0;
            if (w.first) begin
                min_seen[w.idx] = x;
                max_seen[w.idx] = x;
                written[w.idx] = 1'b1;
            end else begin
                if (x < min_seen[w.idx]) min_seen[w.idx] = x;
                if (x > max_seen[w.idx]) max_seen[w.idx] = x;
            end
            return;
        end
        span = longint'(max_seen[w.idx]) - longint'(min_seen[w.idx]);
        diff = longint'(x) - longint'(min_seen[w.idx]);
        if (span <= 0 || diff <= 0) begin
            r.scaled = ZERO_Q16;
        end else if (diff >= span) begin
            r.scaled = ONE_Q16;
        end else begin
            r.scaled = SCL_W'((diff <<< 16) / span);
        end
    endfunction

    function automatic logic [VAL_W-1:0] draw_value(int style);
        if (style == 0) return $urandom;
        return VAL_W'(int'($urandom_range(0, 4000)) - 2000) << $urandom_range(0, 16);
    endfunction

    // mostly values inside the observed span, endpoints included
    function automatic logic [VAL_W-1:0] near_value(logic [IDX_W-1:0] idx, int style);
        longint span;
        int     sel;
        span = longint'(max_seen[idx]) - longint'(min_seen[idx]);
        sel = $urandom_range(0, 7);
        if (sel == 0) return min_seen[idx];
        if (sel == 1) return max_seen[idx];
        if (sel < 6) return VAL_W'(longint'(min_seen[idx]) + longint'($urandom) % (span + 1));
        return draw_value(style);
    endfunction

    function automatic t_in_word noise_word();
        t_in_word w;
        w = '{1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, DEPTH - 1)),
              1'($urandom_range(0, 1)), VAL_W'($urandom)};
        // never read a feature that holds nothing yet
        if (index_ok(w.idx) && !written[w.idx] && (w.kind == KIND_SCALE || !w.first)) begin
            w.kind = KIND_OBSERVE;
            w.first = 1'b1;
        end
        return w;
    endfunction

    task automatic report_mismatch(input string field, input t_scaled_word got,
                                   input t_scaled_word want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch %s: got scaled=%0d index=%0d err=%0b want scaled=%0d index=%0d err=%0b",
                     field, got.scaled, got.idx, got.err, want.scaled, want.idx, want.err);
    endtask

    task automatic check_result();
        t_scaled_word got;
        t_scaled_word want;
        got = '{out_ch.scaled_value, out_ch.result_index, out_ch.index_error};
        if (due_results.size() == 0) begin
            report_mismatch("unexpected word", got, '0);
            return;
        end
        want = due_results.pop_front();
        if (got.scaled !== want.scaled) report_mismatch("scaled_value", got, want);
        if (got.idx !== want.idx) report_mismatch("result_index", got, want);
        if (got.err !== want.err) report_mismatch("index_error", got, want);
    endtask

    task automatic send_word(input t_in_word w, input bit known, input t_scaled_word want);
        int           gap;
        bit           has;
        t_scaled_word r;
        gap = snd_idle ? $urandom_range(0, 14) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid = 1'b1;
        in_ch.kind = w.kind;
        in_ch.feature_index = w.idx;
        in_ch.first_row = w.first;
        in_ch.sample_value = w.val;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        normalize_word(w, has, r);
        if (has) due_results = {due_results, (known ? want : r)};
        words_sent++;
    endtask

    task automatic pause_for_results();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] v);
        pause_for_results();
        // observe words give no result, let the last one finish
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = v;
        @(posedge i_clk);
        feature_limit = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic run_phase(input bit force_pressure);
        logic [CNT_W-1:0] cnt;
        int               usable;
        int               nfeat;
        int               nsamp;
        int               style;
        logic [IDX_W-1:0] cols [$];
        case ($urandom_range(0, 5))
            0: cnt = CNT_W'(1);
            1: cnt = COUNT_RESET;
            2: cnt = '1;
            3: cnt = CNT_W'($urandom_range(2, 16));
            default: cnt = CNT_W'($urandom_range(1, DEPTH));
        endcase
        write_count(cnt);
        snd_idle = $urandom_range(0, 3) != 0;
        rcv_idle = $urandom_range(0, 3) != 0;
        usable = int'(cnt) > DEPTH ? DEPTH : int'(cnt);
        nfeat = $urandom_range(1, usable < 6 ? usable : 6);
        // enough scale words to fill the block during a long hold
        nsamp = force_pressure ? 6 : $urandom_range(1, 6);
        style = $urandom_range(0, 1);
        repeat (nfeat) cols = {cols, IDX_W'($urandom_range(0, usable - 1))};
        for (int s = 0; s < nsamp; s++) begin
            foreach (cols[f]) begin
                if ($urandom_range(0, 7) == 0) send_word(noise_word(), 1'b0, '0);
                send_word('{KIND_OBSERVE, cols[f], s == 0, draw_value(style)}, 1'b0, '0);
            end
        end
        if (force_pressure || $urandom_range(0, 3) == 0) pause_for_results();
        if (force_pressure || $urandom_range(0, 2) == 0) hold_req = 1'b1;
        for (int s = 0; s < nsamp; s++) begin
            foreach (cols[f]) begin
                if ($urandom_range(0, 7) == 0) send_word(noise_word(), 1'b0, '0);
                send_word('{KIND_SCALE, cols[f], 1'($urandom_range(0, 1)),
                            near_value(cols[f], style)}, 1'b0, '0);
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // result side
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                @(negedge i_clk);
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            stall = rcv_idle ? $urandom_range(0, 14) : 0;
            repeat (stall) begin
                @(negedge i_clk);
                out_ch.ready = 1'b0;
            end
            @(negedge i_clk);
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            check_result();
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || i_cfg_we || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        int phase_no;
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_OBSERVE;
        in_ch.feature_index = '0;
        in_ch.first_row = 1'b0;
        in_ch.sample_value = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].op == ROW_CFG) begin
                write_count(directed_rows[i].val[CNT_W-1:0]);
            end else begin
                send_word('{directed_rows[i].kind, directed_rows[i].idx,
                            directed_rows[i].first, directed_rows[i].val},
                          directed_rows[i].known,
                          '{directed_rows[i].want_scaled, directed_rows[i].idx,
                            directed_rows[i].want_err});
            end
        end

        words_sent = 0;
        phase_no = 0;
        while (words_sent < RANDOM_WORDS) begin
            run_phase(phase_no == 1);
            phase_no++;
        end

        pause_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

### min_max_feature_scaler_core.f
rtl/mmfs_pkg.sv
rtl/mmfs_if.sv
rtl/mmfs_store.sv
rtl/mmfs_div.sv
rtl/min_max_feature_scaler_core.sv
dv/tb.sv
